/* rtl/spd_pkg.sv */
// ----------------------------------------------------------------------------
// spd_pkg: shared types and constants for the spherical point distance block
// Item formats, fixed-point constants and pipeline latencies.
// ----------------------------------------------------------------------------
package spd_pkg;

  // Q30 fixed-point unity and rounding half bit
  localparam logic [30:0] OneQ30  = 31'h4000_0000;
  localparam logic [63:0] HalfQ30 = 64'h0000_0000_2000_0000;
  // pi in Q30, rounded
  localparam logic [63:0] PiQ30   = 64'd3373259426;

  // Horner steps of the sine series, k = 7 down to 1
  localparam int unsigned HornerSteps = 7;
  // divisors 2k(2k+1)
  localparam logic [7:0]  HornerDiv [HornerSteps] = '{
    8'd210, 8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6
  };
  // floor(2^34 / divisor)
  localparam logic [31:0] HornerRecip [HornerSteps] = '{
    32'd81808900, 32'd110127366, 32'd156180628, 32'd238609294,
    32'd409044504, 32'd858993459, 32'd2863311530
  };

  // pipeline latencies in cycles
  localparam int unsigned SineLat  = 25;
  localparam int unsigned IsqrtLat = 32;

  // one input item: two points
  typedef struct packed {
    logic        [30:0] first_rho;
    logic        [31:0] first_theta;
    logic signed [31:0] first_phi;
    logic        [30:0] second_rho;
    logic        [31:0] second_theta;
    logic signed [31:0] second_phi;
  } spd_item_t;

  // one result item
  typedef struct packed {
    logic signed [31:0] cosine_between;
    logic signed [63:0] dot_product;
    logic        [63:0] distance_squared;
    logic        [31:0] distance;
  } spd_result_t;

  // signed Q30 sine as magnitude and sign
  typedef struct packed {
    logic [30:0] mag;
    logic        neg;
  } spd_sine_t;

endpackage

/* rtl/spd_sine.sv */
// ----------------------------------------------------------------------------
// spd_sine: pipelined Q30 sine
// Quadrant reduction, radian scaling and a seven step Horner series,
// three stages per step. One item per cycle.
// ----------------------------------------------------------------------------
module spd_sine import spd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic        half_i,   // 1: |sin(d/2)|, 0: signed sin(p)
  input  logic [31:0] phase_i,
  output logic        valid_o,
  output spd_sine_t   sine_o
);

  // reduction stage
  logic [31:0] r31_d, r31_q;
  logic        neg_d, neg0_q, v0_q;

  always_comb begin
    if (half_i) begin
      r31_d = {1'b0, phase_i[30:0]};
      if (phase_i[31]) begin
        r31_d = 32'h8000_0000 - r31_d;
      end
      neg_d = 1'b0;
    end else begin
      r31_d = {1'b0, phase_i[29:0], 1'b0};
      if (phase_i[30]) begin
        r31_d = 32'h8000_0000 - r31_d;
      end
      neg_d = phase_i[31];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    r31_q  <= r31_d;
    neg0_q <= neg_d;
  end

  // radian scaling: x = round(r31 * pi / 2^32)
  logic [63:0] xs_sum;
  logic [30:0] x1_q;
  logic        neg1_q, v1_q;

  assign xs_sum = {32'b0, r31_q} * PiQ30 + 64'h0000_0000_8000_0000;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q   <= xs_sum[62:32];
    neg1_q <= neg0_q;
  end

  // x squared in Q30
  logic [63:0] sq_sum;
  assign sq_sum = {33'b0, x1_q} * {33'b0, x1_q} + HalfQ30;

  // per-step pipeline taps; index HornerSteps is the series output
  logic        vs   [HornerSteps+1];
  logic [30:0] xs   [HornerSteps+1];
  logic [31:0] x2s  [HornerSteps+1];
  logic [30:0] ts   [HornerSteps+1];
  logic        ns   [HornerSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs[0] <= 1'b0;
    end else begin
      vs[0] <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    xs[0]  <= x1_q;
    x2s[0] <= sq_sum[61:30];
    ts[0]  <= OneQ30;
    ns[0]  <= neg1_q;
  end

  // Horner steps: t = 1 - round(x2*t) / (2k(2k+1))
  for (genvar i = 0; i < HornerSteps; i++) begin : g_step
    localparam logic [31:0] Recip = HornerRecip[i];
    localparam logic [7:0]  Div   = HornerDiv[i];

    logic        va_q, vb_q, vc_q;
    logic [30:0] xa_q, xb_q, xc_q;
    logic [31:0] x2a_q, x2b_q, x2c_q;
    logic        na_q, nb_q, nc_q;
    logic [31:0] pa_q, pb_q;
    logic [29:0] qe_q;
    logic [30:0] tc_q;
    logic [63:0] pm;
    logic [63:0] qm;
    logic [39:0] qd;
    logic [39:0] rem;
    logic [30:0] q;

    // product x2 * t, rounded
    assign pm = {32'b0, x2s[i]} * {33'b0, ts[i]} + HalfQ30;
    // estimate by reciprocal, low by at most one
    assign qm = {32'b0, pa_q} * {32'b0, Recip};
    // one correction step
    assign qd  = {10'b0, qe_q} * {32'b0, Div};
    assign rem = {8'b0, pb_q} - qd;
    assign q   = {1'b0, qe_q} + {30'b0, (rem >= {32'b0, Div})};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        va_q <= 1'b0;
        vb_q <= 1'b0;
        vc_q <= 1'b0;
      end else begin
        va_q <= vs[i];
        vb_q <= va_q;
        vc_q <= vb_q;
      end
    end

    always_ff @(posedge clk_i) begin
      xa_q  <= xs[i];
      x2a_q <= x2s[i];
      na_q  <= ns[i];
      pa_q  <= pm[61:30];
      xb_q  <= xa_q;
      x2b_q <= x2a_q;
      nb_q  <= na_q;
      pb_q  <= pa_q;
      qe_q  <= qm[63:34];
      xc_q  <= xb_q;
      x2c_q <= x2b_q;
      nc_q  <= nb_q;
      tc_q  <= (q >= OneQ30) ? 31'd0 : OneQ30 - q;
    end

    assign vs[i+1]  = vc_q;
    assign xs[i+1]  = xc_q;
    assign x2s[i+1] = x2c_q;
    assign ts[i+1]  = tc_q;
    assign ns[i+1]  = nc_q;
  end

  // final product x * t, capped at one
  logic [63:0] fs_sum;
  logic        vf_q;
  spd_sine_t   sine_q;

  assign fs_sum = {33'b0, xs[HornerSteps]} * {33'b0, ts[HornerSteps]} + HalfQ30;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else begin
      vf_q <= vs[HornerSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    sine_q.mag <= (fs_sum[61:30] > {1'b0, OneQ30}) ? OneQ30 : fs_sum[60:30];
    sine_q.neg <= ns[HornerSteps];
  end

  assign valid_o = vf_q;
  assign sine_o  = sine_q;

endmodule

/* rtl/spd_combine.sv */
// ----------------------------------------------------------------------------
// spd_combine: haversine cosine, dot product and squared distance
// Six register stages, at most one multiplier level per stage.
// ----------------------------------------------------------------------------
module spd_combine import spd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  spd_sine_t          st_i,   // |sin(dtheta/2)|
  input  spd_sine_t          sp_i,   // |sin(dphi/2)|
  input  spd_sine_t          s1_i,   // sin(theta1)
  input  spd_sine_t          s2_i,   // sin(theta2)
  input  logic        [30:0] r1_i,
  input  logic        [30:0] r2_i,
  output logic               valid_o,
  output logic signed [31:0] cos_o,
  output logic signed [63:0] dot_o,
  output logic        [63:0] dist2_o
);

  logic [5:0] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  // stage 0: squares of the half sines, sine product, radius products
  logic [63:0] a_m, sp2_m, b_m;
  logic [30:0] a0_q, sp20_q, b0_q;
  logic        bn0_q;
  logic [61:0] prod0_q, r1sq0_q, r2sq0_q;

  assign a_m   = {33'b0, st_i.mag} * {33'b0, st_i.mag} + HalfQ30;
  assign sp2_m = {33'b0, sp_i.mag} * {33'b0, sp_i.mag} + HalfQ30;
  assign b_m   = {33'b0, s1_i.mag} * {33'b0, s2_i.mag} + HalfQ30;

  always_ff @(posedge clk_i) begin
    a0_q    <= a_m[60:30];
    sp20_q  <= sp2_m[60:30];
    b0_q    <= b_m[60:30];
    bn0_q   <= s1_i.neg ^ s2_i.neg;
    prod0_q <= r1_i * r2_i;
    r1sq0_q <= r1_i * r1_i;
    r2sq0_q <= r2_i * r2_i;
  end

  // stage 1: c = b * sp2, sum of radius squares
  logic [63:0] c_m;
  logic [30:0] a1_q, c1_q;
  logic        cn1_q;
  logic [61:0] prod1_q;
  logic [62:0] sq1_q;

  assign c_m = {33'b0, b0_q} * {33'b0, sp20_q} + HalfQ30;

  always_ff @(posedge clk_i) begin
    a1_q    <= a0_q;
    c1_q    <= c_m[60:30];
    cn1_q   <= bn0_q;
    prod1_q <= prod0_q;
    sq1_q   <= {1'b0, r1sq0_q} + {1'b0, r2sq0_q};
  end

  // stage 2: cos = 1 - 2(a + c), clamped to [-1, 1]
  logic signed [33:0] sum_c, cos_c;
  logic signed [33:0] cos_cl;
  logic signed [31:0] cos2_q;
  logic        [30:0] mag2_q;
  logic               neg2_q;
  logic        [61:0] prod2_q;
  logic        [62:0] sq2_q;

  always_comb begin
    sum_c = cn1_q ? $signed({3'b0, a1_q}) - $signed({3'b0, c1_q})
                  : $signed({3'b0, a1_q}) + $signed({3'b0, c1_q});
    cos_c = $signed({3'b0, OneQ30}) - (sum_c <<< 1);
    cos_cl = cos_c;
    if (cos_c > $signed({3'b0, OneQ30})) begin
      cos_cl = $signed({3'b0, OneQ30});
    end
    if (cos_c < -$signed({3'b0, OneQ30})) begin
      cos_cl = -$signed({3'b0, OneQ30});
    end
  end

  always_ff @(posedge clk_i) begin
    cos2_q  <= cos_cl[31:0];
    neg2_q  <= cos_cl[33];
    mag2_q  <= cos_cl[33] ? 31'(-cos_cl) : cos_cl[30:0];
    prod2_q <= prod1_q;
    sq2_q   <= sq1_q;
  end

  // stage 3: split product of radius product and |cos|
  logic [63:0] lp_m;
  logic [62:0] hp3_q;
  logic [31:0] lp3_q;
  logic signed [31:0] cos3_q;
  logic        neg3_q;
  logic [62:0] sq3_q;

  assign lp_m = {34'b0, prod2_q[29:0]} * {33'b0, mag2_q} + HalfQ30;

  always_ff @(posedge clk_i) begin
    hp3_q  <= prod2_q[61:30] * mag2_q;
    lp3_q  <= lp_m[61:30];
    cos3_q <= cos2_q;
    neg3_q <= neg2_q;
    sq3_q  <= sq2_q;
  end

  // stage 4: dot magnitude
  logic [62:0] m4_q;
  logic signed [31:0] cos4_q;
  logic        neg4_q;
  logic [62:0] sq4_q;

  always_ff @(posedge clk_i) begin
    m4_q   <= hp3_q + {31'b0, lp3_q};
    cos4_q <= cos3_q;
    neg4_q <= neg3_q;
    sq4_q  <= sq3_q;
  end

  // stage 5: signed dot, |sq - 2 dot| with saturation
  logic [64:0] add_s;
  logic [63:0] d2, sq64, dist2_c;
  logic signed [31:0] cos5_q;
  logic signed [63:0] dot5_q;
  logic        [63:0] dist5_q;

  always_comb begin
    d2    = {m4_q, 1'b0};
    sq64  = {1'b0, sq4_q};
    add_s = {1'b0, sq64} + {1'b0, d2};
    if (neg4_q) begin
      dist2_c = add_s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : add_s[63:0];
    end else begin
      dist2_c = (sq64 >= d2) ? sq64 - d2 : d2 - sq64;
    end
  end

  always_ff @(posedge clk_i) begin
    cos5_q  <= cos4_q;
    dot5_q  <= neg4_q ? -$signed({1'b0, m4_q}) : $signed({1'b0, m4_q});
    dist5_q <= dist2_c;
  end

  assign valid_o = v_q[5];
  assign cos_o   = cos5_q;
  assign dot_o   = dot5_q;
  assign dist2_o = dist5_q;

endmodule

/* rtl/spd_isqrt.sv */
// ----------------------------------------------------------------------------
// spd_isqrt: pipelined 64-bit integer square root
// Bit by bit root, one compare and subtract per stage, IsqrtLat stages.
// ----------------------------------------------------------------------------
module spd_isqrt import spd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [63:0] n_i,
  output logic        valid_o,
  output logic [31:0] root_o
);

  logic        vs [IsqrtLat+1];
  logic [63:0] ns [IsqrtLat+1];
  logic [63:0] rs [IsqrtLat+1];

  assign vs[0] = valid_i;
  assign ns[0] = n_i;
  assign rs[0] = '0;

  for (genvar i = 0; i < IsqrtLat; i++) begin : g_bit
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * i);

    logic        v_q;
    logic [63:0] n_q, r_q;
    logic [63:0] trial;

    assign trial = rs[i] + Bit;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else begin
        v_q <= vs[i];
      end
    end

    // keep the bit where the remainder allows it
    always_ff @(posedge clk_i) begin
      if (ns[i] >= trial) begin
        n_q <= ns[i] - trial;
        r_q <= (rs[i] >> 1) + Bit;
      end else begin
        n_q <= ns[i];
        r_q <= rs[i] >> 1;
      end
    end

    assign vs[i+1] = v_q;
    assign ns[i+1] = n_q;
    assign rs[i+1] = r_q;
  end

  assign valid_o = vs[IsqrtLat];
  assign root_o  = rs[IsqrtLat][31:0];

endmodule

/* rtl/spherical_point_distance.sv */
// ----------------------------------------------------------------------------
// spherical_point_distance: separation of two points in spherical coordinates
// An item is a pair of points (radius, colatitude, longitude). It is taken
// at a rising edge where start_i is high and busy_o is low; busy_o is always
// low, so a new item may be given every cycle. Each item yields one result
// on result_o, marked by result_valid_o for exactly one cycle: the cosine of
// the separation angle, the dot product, the saturated squared chord
// distance and its integer square root.
// Items pass through the sine pipelines (Horner series, three stages per
// term), then the combine stages and the square root, which retires one
// root bit per stage. Throughput is one item per cycle.
// Reset clears only the valid bits; items in flight are dropped. The
// receiver cannot stall, so results leave in acceptance order unhindered.
// ----------------------------------------------------------------------------
module spherical_point_distance import spd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  spd_item_t   item_i,
  output logic        busy_o,
  output logic        result_valid_o,
  output spd_result_t result_o
);

  logic        take;
  logic [31:0] dtheta, dphi;

  assign busy_o = 1'b0;
  assign take   = start_i & ~busy_o;
  assign dtheta = item_i.first_theta - item_i.second_theta;
  assign dphi   = item_i.first_phi - item_i.second_phi;

  // sines of the half differences and of both colatitudes
  logic      sv;
  spd_sine_t st, sp, s1, s2;

  spd_sine u_sine_dt (
    .clk_i, .rst_ni, .valid_i(take), .half_i(1'b1), .phase_i(dtheta),
    .valid_o(sv), .sine_o(st)
  );
  spd_sine u_sine_dp (
    .clk_i, .rst_ni, .valid_i(take), .half_i(1'b1), .phase_i(dphi),
    .valid_o(), .sine_o(sp)
  );
  spd_sine u_sine_t1 (
    .clk_i, .rst_ni, .valid_i(take), .half_i(1'b0), .phase_i(item_i.first_theta),
    .valid_o(), .sine_o(s1)
  );
  spd_sine u_sine_t2 (
    .clk_i, .rst_ni, .valid_i(take), .half_i(1'b0), .phase_i(item_i.second_theta),
    .valid_o(), .sine_o(s2)
  );

  // radii ride alongside the sine pipelines
  logic [30:0] r1_dly_q [SineLat];
  logic [30:0] r2_dly_q [SineLat];

  always_ff @(posedge clk_i) begin
    r1_dly_q[0] <= item_i.first_rho;
    r2_dly_q[0] <= item_i.second_rho;
    for (int i = 1; i < SineLat; i++) begin
      r1_dly_q[i] <= r1_dly_q[i-1];
      r2_dly_q[i] <= r2_dly_q[i-1];
    end
  end

  // cosine, dot product, squared distance
  logic               cv;
  logic signed [31:0] cosv;
  logic signed [63:0] dotv;
  logic        [63:0] dist2;

  spd_combine u_combine (
    .clk_i, .rst_ni, .valid_i(sv),
    .st_i(st), .sp_i(sp), .s1_i(s1), .s2_i(s2),
    .r1_i(r1_dly_q[SineLat-1]), .r2_i(r2_dly_q[SineLat-1]),
    .valid_o(cv), .cos_o(cosv), .dot_o(dotv), .dist2_o(dist2)
  );

  // distance by square root; other fields wait alongside
  logic        qv;
  logic [31:0] root;

  spd_isqrt u_isqrt (
    .clk_i, .rst_ni, .valid_i(cv), .n_i(dist2), .valid_o(qv), .root_o(root)
  );

  logic signed [31:0] cos_dly_q   [IsqrtLat];
  logic signed [63:0] dot_dly_q   [IsqrtLat];
  logic        [63:0] dist2_dly_q [IsqrtLat];

  always_ff @(posedge clk_i) begin
    cos_dly_q[0]   <= cosv;
    dot_dly_q[0]   <= dotv;
    dist2_dly_q[0] <= dist2;
    for (int i = 1; i < IsqrtLat; i++) begin
      cos_dly_q[i]   <= cos_dly_q[i-1];
      dot_dly_q[i]   <= dot_dly_q[i-1];
      dist2_dly_q[i] <= dist2_dly_q[i-1];
    end
  end

  assign result_valid_o            = qv;
  assign result_o.cosine_between   = cos_dly_q[IsqrtLat-1];
  assign result_o.dot_product      = dot_dly_q[IsqrtLat-1];
  assign result_o.distance_squared = dist2_dly_q[IsqrtLat-1];
  assign result_o.distance         = root;

endmodule

/* dv/tb_spherical_point_distance.sv */
// ----------------------------------------------------------------------------
// tb_spherical_point_distance: self-checking bench for the distance block
// Drives point pairs through the command handshake, predicts each result with
// an independent fixed-point model and compares every field in order. A short
// table of directed pairs comes first, then about 1300 random pairs.
// ----------------------------------------------------------------------------
module tb_spherical_point_distance;
  import spd_pkg::*;

  localparam int unsigned NumRandom  = 1300;
  localparam int unsigned DrainWait  = 100;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned NumDirect  = 14;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  spd_item_t   item_i;
  logic        busy_o;
  logic        result_valid_o;
  spd_result_t result_o;

  spd_result_t expected_q[$];
  int unsigned err_cnt;
  int unsigned cycle_cnt;

  // directed row: item plus an optional typed-in result
  typedef struct {
    spd_item_t   pair;
    bit          has_known;
    spd_result_t known;
  } direct_row_t;

  direct_row_t direct_tbl[NumDirect];

  spherical_point_distance dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .item_i         (item_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Q30 sine of an in-quadrant offset, Taylor series by Horner
  function automatic logic [63:0] quad_sine(logic [63:0] r31);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] p;
    logic [63:0] q;
    logic [63:0] s;
    x  = (r31 * PiQ30 + 64'h8000_0000) >> 32;
    x2 = (x * x + HalfQ30) >> 30;
    t  = 64'h4000_0000;
    for (int k = 7; k >= 1; k--) begin
      p = (x2 * t + HalfQ30) >> 30;
      q = p / ((2 * k) * (2 * k + 1));
      t = (q >= 64'h4000_0000) ? 64'd0 : 64'h4000_0000 - q;
    end
    s = (x * t + HalfQ30) >> 30;
    return (s > 64'h4000_0000) ? 64'h4000_0000 : s;
  endfunction

  // signed sine of a full-turn phase
  function automatic longint phase_sine(logic [31:0] ph);
    logic [63:0] r31;
    logic [63:0] m;
    r31 = {33'd0, ph[29:0], 1'b0};
    if (ph[30]) r31 = 64'h8000_0000 - r31;
    m = quad_sine(r31);
    return ph[31] ? -longint'(m) : longint'(m);
  endfunction

  // |sin(d/2)|
  function automatic logic [63:0] half_sine(logic [31:0] d);
    logic [63:0] r31;
    r31 = {33'd0, d[30:0]};
    if (d[31]) r31 = 64'h8000_0000 - r31;
    return quad_sine(r31);
  endfunction

  function automatic longint q30_mul(longint a, longint b);
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] m;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    m  = (ma * mb + HalfQ30) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [31:0] floor_root(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b   = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (n >= res + b) begin
        n   = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res[31:0];
  endfunction

  // predicted result of one point pair
  function automatic spd_result_t pair_separation(spd_item_t it);
    spd_result_t r;
    logic [63:0] r1;
    logic [63:0] r2;
    logic [63:0] st;
    logic [63:0] sp;
    longint      a;
    longint      sp2;
    longint      bb;
    longint      c;
    longint      cosv;
    logic [63:0] prod;
    logic [63:0] mag;
    logic [63:0] m;
    logic [63:0] sq;
    logic [63:0] d2;
    logic [63:0] dist2;
    logic        neg;
    r1   = {33'd0, it.first_rho};
    r2   = {33'd0, it.second_rho};
    st   = half_sine(it.first_theta - it.second_theta);
    sp   = half_sine(it.first_phi - it.second_phi);
    a    = (st * st + HalfQ30) >> 30;
    sp2  = (sp * sp + HalfQ30) >> 30;
    bb   = q30_mul(phase_sine(it.first_theta), phase_sine(it.second_theta));
    c    = q30_mul(bb, sp2);
    cosv = 64'sh4000_0000 - 2 * (a + c);
    if (cosv > 64'sh4000_0000) cosv = 64'sh4000_0000;
    if (cosv < -64'sh4000_0000) cosv = -64'sh4000_0000;
    prod = r1 * r2;
    neg  = cosv < 0;
    mag  = neg ? -cosv : cosv;
    m    = (prod >> 30) * mag + (((prod & 64'h3FFF_FFFF) * mag + HalfQ30) >> 30);
    sq   = r1 * r1 + r2 * r2;
    d2   = 2 * m;
    if (neg) begin
      dist2 = sq + d2;
      if (dist2 < sq) dist2 = '1;
    end else begin
      dist2 = (sq >= d2) ? sq - d2 : d2 - sq;
    end
    r.cosine_between   = cosv[31:0];
    r.dot_product      = neg ? -m : m;
    r.distance_squared = dist2;
    r.distance         = floor_root(dist2);
    return r;
  endfunction

  function automatic spd_item_t mk_pair(logic [30:0] r1, logic [31:0] t1, logic [31:0] p1,
                                        logic [30:0] r2, logic [31:0] t2, logic [31:0] p2);
    spd_item_t it;
    it.first_rho  = r1;  it.first_theta  = t1;  it.first_phi  = p1;
    it.second_rho = r2;  it.second_theta = t2;  it.second_phi = p2;
    return it;
  endfunction

  function automatic logic [31:0] rand_theta();
    logic [31:0] v;
    case ($urandom_range(9))
      0:       v = 32'h8000_0000;
      1:       v = 32'd0;
      2:       v = $urandom;  // beyond pi, periodic
      default: v = $urandom_range(32'h8000_0000);
    endcase
    return v;
  endfunction

  function automatic logic [30:0] rand_rho();
    logic [30:0] v;
    case ($urandom_range(7))
      0:       v = '1;
      1:       v = 31'd0;
      2:       v = 31'($urandom_range(65535));
      default: v = 31'($urandom);
    endcase
    return v;
  endfunction

  // random gap, mostly short, a few long
  task automatic idle_gap();
    int unsigned n;
    n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(2);
    if ($urandom_range(3) == 0) n = 0;
    repeat (n) @(negedge clk_i);
  endtask

  // present one pair and hold it until accepted
  task automatic send_pair(spd_item_t it);
    start_i = 1'b1;
    item_i  = it;
    do @(posedge clk_i); while (busy_o);
    expected_q.push_back(pair_separation(it));
    @(negedge clk_i);
    start_i = 1'b0;
  endtask

  // result checking at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result_o);
        err_cnt++;
      end else begin
        spd_result_t e;
        e = expected_q.pop_front();
        if (e.cosine_between !== result_o.cosine_between) begin
          $display("%0t: cosine_between exp %0d got %0d", $time,
                   e.cosine_between, result_o.cosine_between);
          err_cnt++;
        end
        if (e.dot_product !== result_o.dot_product) begin
          $display("%0t: dot_product exp %0d got %0d", $time,
                   e.dot_product, result_o.dot_product);
          err_cnt++;
        end
        if (e.distance_squared !== result_o.distance_squared) begin
          $display("%0t: distance_squared exp %0d got %0d", $time,
                   e.distance_squared, result_o.distance_squared);
          err_cnt++;
        end
        if (e.distance !== result_o.distance) begin
          $display("%0t: distance exp %0d got %0d", $time, e.distance, result_o.distance);
          err_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("spherical_point_distance test failed");
      $finish;
    end
  end

  initial begin
    spd_result_t zero_res;
    spd_item_t   it;
    int unsigned wait_cnt;
    err_cnt   = 0;
    cycle_cnt = 0;
    rst_ni    = 1'b0;
    start_i   = 1'b0;
    item_i    = '0;
    zero_res  = '0;
    zero_res.cosine_between = 32'sh4000_0000;

    // directed pairs: extremes, coincident points, antipodes, theta past pi
    direct_tbl[0]  = '{mk_pair(0, 0, 0, 0, 0, 0), 1'b1, zero_res};
    direct_tbl[1]  = '{mk_pair('1, 0, 0, '1, 0, 0), 1'b0, zero_res};
    direct_tbl[2]  = '{mk_pair('1, 32'h8000_0000, 32'h8000_0000, '1, 0, 32'h7FFF_FFFF),
                       1'b0, zero_res};
    direct_tbl[3]  = '{mk_pair('1, 32'h4000_0000, 32'h8000_0000, '1, 32'h4000_0000, 0),
                       1'b0, zero_res};
    direct_tbl[4]  = '{mk_pair(256, 32'h4000_0000, 0, 256, 32'h4000_0000, 32'h4000_0000),
                       1'b0, zero_res};
    direct_tbl[5]  = '{mk_pair(1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, 32'h8000_0000,
                               32'h8000_0000), 1'b0, zero_res};
    direct_tbl[6]  = '{mk_pair('1, 32'hC000_0000, 32'h1234_5678, 1, 32'h2000_0000,
                               32'hEDCB_A988), 1'b0, zero_res};
    direct_tbl[7]  = '{mk_pair(31'h5555_5555, 32'h2AAA_AAAA, 32'h5555_5555, 31'h2AAA_AAAA,
                               32'h5555_5555, 32'hAAAA_AAAA), 1'b0, zero_res};
    direct_tbl[8]  = '{mk_pair('1, 0, 0, 0, 32'h8000_0000, 0), 1'b0, zero_res};
    direct_tbl[9]  = '{mk_pair(1000, 32'h8000_0000, 0, 1000, 32'h8000_0000, 32'h8000_0000),
                       1'b0, zero_res};
    direct_tbl[10] = '{mk_pair(12345, 32'h1000_0000, 32'h0000_0001, 12345, 32'h1000_0001,
                               0), 1'b0, zero_res};
    direct_tbl[11] = '{mk_pair('1, 32'h7FFF_FFFF, 32'hFFFF_FFFF, '1, 32'h8000_0001, 1),
                       1'b0, zero_res};
    direct_tbl[12] = '{mk_pair(31'h4000_0000, 32'h9000_0000, 32'h6000_0000, 31'h3FFF_FFFF,
                               32'hF000_0000, 32'hA000_0000), 1'b0, zero_res};
    direct_tbl[13] = '{mk_pair('1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, 32'hFFFF_FFFF,
                               32'h8000_0000), 1'b0, zero_res};

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (direct_tbl[i]) begin
      // typed-in rows must agree with the predictor as well
      if (direct_tbl[i].has_known &&
          pair_separation(direct_tbl[i].pair) !== direct_tbl[i].known) begin
        $display("%0t: row %0d exp %h got %h", $time, i, direct_tbl[i].known,
                 pair_separation(direct_tbl[i].pair));
        err_cnt++;
      end
      send_pair(direct_tbl[i].pair);
      if (i % 3 == 0) idle_gap();
    end

    // let the pipeline empty once before random traffic
    while (expected_q.size() != 0) @(negedge clk_i);

    for (int n = 0; n < NumRandom; n++) begin
      it = mk_pair(rand_rho(), rand_theta(), $urandom, rand_rho(), rand_theta(), $urandom);
      // sometimes nearby points, to exercise small separations
      if ($urandom_range(4) == 0) begin
        it.second_theta = it.first_theta + $urandom_range(64) - 32;
        it.second_phi   = it.first_phi + $urandom_range(64) - 32;
      end
      send_pair(it);
      if (n == NumRandom / 2) begin
        while (expected_q.size() != 0) @(negedge clk_i);
      end
      // bursts without gaps between idle stretches
      if ((n / 100) % 2 == 1) idle_gap();
    end

    wait_cnt = 0;
    while (expected_q.size() != 0 && wait_cnt < 10 * DrainWait) begin
      @(negedge clk_i);
      wait_cnt++;
    end
    repeat (DrainWait) @(negedge clk_i);
    if (err_cnt == 0 && expected_q.size() == 0) begin
      $display("spherical_point_distance test passed");
    end else begin
      $display("spherical_point_distance test failed");
    end
    $finish;
  end

endmodule
